>>> rtl/itok_pkg.sv
// ----------------------------------------------------------------------------
// itok_pkg
// Types and constants shared by the integer pair sequence tokenizer.
// ----------------------------------------------------------------------------
package itok_pkg;

    localparam int COUNT_W = 11;
    localparam int VALUE_W = 31;

    // hard ceiling on values per sequence
    localparam logic [COUNT_W-1:0] MAX_LENGTH = 11'd1024;
    localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 11'd1024;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_END    = 2'd1,
        ST_LONG   = 2'd2,
        ST_FORMAT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_SPACE,
        TK_SEMI,
        TK_EOL,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic               has_value;
        logic [VALUE_W-1:0] value;
        logic               sequence_id;
        logic               last_in_sequence;
        logic [COUNT_W-1:0] seq_length;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        token_t tok;
    } q_head_t;

endpackage

>>> rtl/itok_front.sv
// ----------------------------------------------------------------------------
// itok_front
// Classifies one incoming character into a token for the back end.
// ----------------------------------------------------------------------------
module itok_front
    import itok_pkg::*;
(
    input  in_item_t item,
    output token_t   tok
);

    always_comb
    begin
        tok.digit = 4'(item.char_code - CH_ZERO);
        if (item.end_of_input || item.char_code == CH_NEWLINE)
        begin
            tok.kind = TK_EOL;
        end
        else if (item.char_code inside {[CH_ZERO:CH_NINE]})
        begin
            tok.kind = TK_DIGIT;
        end
        else if (item.char_code == CH_SPACE)
        begin
            tok.kind = TK_SPACE;
        end
        else if (item.char_code == CH_SEMI)
        begin
            tok.kind = TK_SEMI;
        end
        else
        begin
            tok.kind = TK_OTHER;
        end
    end

endmodule

>>> rtl/itok_queue.sv
// ----------------------------------------------------------------------------
// itok_queue
// Small token FIFO between the classifier and the back end.
// ----------------------------------------------------------------------------
module itok_queue
    import itok_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  token_t  push_tok,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    token_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.tok   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("token popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/itok_back.sv
// ----------------------------------------------------------------------------
// itok_back
// Runs the tokenizer state on each token and holds the result item.
// ----------------------------------------------------------------------------
module itok_back
    import itok_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    input  q_head_t            head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    logic               max_len_reg;
    logic [COUNT_W-1:0] max_len_val_reg;
    logic               phase_reg, phase_next;
    logic               in_number_reg, in_number_next;
    logic [VALUE_W-1:0] accumulator_reg, accumulator_next;
    logic [COUNT_W-1:0] value_count_reg, value_count_next;
    logic               halted_reg, halted_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               can_issue;
    logic               emit;
    out_item_t          res;
    logic [COUNT_W-1:0] limit;
    logic               too_long;
    logic               got;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] closed_len;
    logic [VALUE_W+3:0] times_ten;

    // max_len_reg only marks that the value register has been loaded since reset
    assign limit = (!max_len_reg) ? MAX_LEN_RESET :
                   (max_len_val_reg > MAX_LENGTH) ? MAX_LENGTH : max_len_val_reg;

    assign can_issue = !out_valid_reg || !out_stall;
    assign pop       = head.valid && can_issue;

    assign too_long   = in_number_reg && (value_count_reg >= limit);
    assign got        = in_number_reg && !too_long;
    assign count_inc  = value_count_reg + COUNT_W'(1);
    assign closed_len = got ? count_inc : value_count_reg;
    // acc*10 + digit, wide enough to detect overflow for saturation
    assign times_ten  = {3'b000, accumulator_reg, 1'b0} + {1'b0, accumulator_reg, 3'b000}
                        + {31'd0, head.tok.digit};

    always_comb
    begin
        phase_next       = phase_reg;
        in_number_next   = in_number_reg;
        accumulator_next = accumulator_reg;
        value_count_next = value_count_reg;
        halted_next      = halted_reg;
        emit             = 1'b0;
        res              = '0;
        res.sequence_id  = phase_reg;
        res.status       = ST_OK;

        if (pop && !halted_reg)
        begin
            case (head.tok.kind)
                TK_DIGIT:
                begin
                    accumulator_next = (times_ten[VALUE_W+3:VALUE_W] != '0) ?
                                       VALUE_MAX : times_ten[VALUE_W-1:0];
                    in_number_next   = 1'b1;
                end
                TK_SPACE:
                begin
                    if (too_long)
                    begin
                        emit        = 1'b1;
                        res.status  = ST_LONG;
                        halted_next = 1'b1;
                    end
                    else if (in_number_reg)
                    begin
                        emit             = 1'b1;
                        res.has_value    = 1'b1;
                        res.value        = accumulator_reg;
                        value_count_next = count_inc;
                        in_number_next   = 1'b0;
                        accumulator_next = '0;
                    end
                end
                TK_SEMI:
                begin
                    emit = 1'b1;
                    if (phase_reg)
                    begin
                        res.status  = ST_FORMAT;
                        halted_next = 1'b1;
                    end
                    else if (too_long)
                    begin
                        res.status  = ST_LONG;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        res.has_value        = got;
                        res.value            = got ? accumulator_reg : '0;
                        res.sequence_id      = 1'b0;
                        res.last_in_sequence = 1'b1;
                        res.seq_length       = closed_len;
                        phase_next           = 1'b1;
                        value_count_next     = '0;
                        in_number_next       = 1'b0;
                        accumulator_next     = '0;
                    end
                end
                TK_EOL:
                begin
                    emit = 1'b1;
                    if (too_long)
                    begin
                        res.status  = ST_LONG;
                        halted_next = 1'b1;
                    end
                    else if (!phase_reg)
                    begin
                        // empty first part ends the data
                        res.status  = (closed_len == '0) ? ST_END : ST_FORMAT;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        res.has_value        = got;
                        res.value            = got ? accumulator_reg : '0;
                        res.sequence_id      = 1'b1;
                        res.last_in_sequence = 1'b1;
                        res.seq_length       = closed_len;
                        phase_next           = 1'b0;
                        value_count_next     = '0;
                        in_number_next       = 1'b0;
                        accumulator_next     = '0;
                    end
                end
                default:
                begin
                    emit        = 1'b1;
                    res.status  = ST_FORMAT;
                    halted_next = 1'b1;
                end
            endcase
        end

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg     <= 1'b0;
            phase_reg       <= 1'b0;
            in_number_reg   <= 1'b0;
            accumulator_reg <= '0;
            value_count_reg <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= 1'b1;
            end
            phase_reg       <= phase_next;
            in_number_reg   <= in_number_next;
            accumulator_reg <= accumulator_next;
            value_count_reg <= value_count_next;
            halted_reg      <= halted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            max_len_val_reg <= cfg_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK) |-> halted_reg)
        else $error("error item shown without halting");

    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.has_value) |-> out_data_reg.status == ST_OK)
        else $error("value carried with non-ok status");

    a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_number_reg |-> accumulator_reg == '0)
        else $error("accumulator not clear between numbers");
`endif

endmodule

>>> rtl/integer_pair_sequence_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// integer_pair_sequence_tokenizer_unit
// Splits "x1 x2 ...; y1 y2 ..." lines into two sequences of decimal values.
// ----------------------------------------------------------------------------
// One character is taken per clock while in_stall is low. A classifier feeds a
// QUEUE_DEPTH-entry token queue, and the back end consumes one token per clock,
// unless out_stall holds a shown result, into a single output register, so a
// result passes through a queue slot and then the output register. in_stall
// rises only when the queue is full, which happens when out_stall holds the
// output register and the queue backs up. After an end-of-data or error item
// the block drops all input until reset.
// ----------------------------------------------------------------------------
module integer_pair_sequence_tokenizer_unit
    import itok_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    token_t  front_tok;
    q_head_t head;
    logic    q_full;
    logic    pop;

    assign in_stall = q_full;

    itok_front u_front
    (
        .item (in_data),
        .tok  (front_tok)
    );

    itok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !q_full),
        .push_tok (front_tok),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    itok_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> tb/sv/itok_stream_checker.sv
// ----------------------------------------------------------------------------
// itok_stream_checker
// Watches the tokenizer channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Each accepted character item is run through a local copy of the tokenizer
// state. The results it causes are queued and matched in order against the
// items leaving the block. Mismatches, surplus results and the number still
// outstanding are handed back to the testbench top.
// ----------------------------------------------------------------------------
module itok_stream_checker
    import itok_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_data,
    output int                 results_due,
    output int                 fail_count,
    output int                 results_checked
);

    localparam int REPORT_MAX = 20;

    logic [COUNT_W-1:0] max_len;
    logic               cur_part;
    logic               in_num;
    logic [VALUE_W-1:0] acc;
    logic [COUNT_W-1:0] value_count;
    logic               halted;

    out_item_t expected_results[$];

    // Ends a pending value; returns 1 when it would break the length limit.
    function automatic bit close_value(output logic got, output logic [VALUE_W-1:0] v);
        logic [COUNT_W-1:0] lim;
        lim = (max_len > MAX_LENGTH) ? MAX_LENGTH : max_len;
        got = 1'b0;
        v = '0;
        if (!in_num)
            return 1'b0;
        if (value_count >= lim)
            return 1'b1;
        got = 1'b1;
        v = acc;
        value_count = value_count + 1'b1;
        in_num = 1'b0;
        acc = '0;
        return 1'b0;
    endfunction

    function automatic out_item_t halt_with(input status_t st);
        out_item_t res;
        res = '0;
        res.sequence_id = cur_part;
        res.status = st;
        halted = 1'b1;
        return res;
    endfunction

    function automatic bit tokenize_char(input in_item_t item, output out_item_t res);
        logic [7:0]         ch;
        logic               eol;
        logic               got;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W+3:0] grown;
        res = '0;
        ch = item.char_code;
        eol = item.end_of_input || (ch == CH_NEWLINE);
        if (halted)
            return 1'b0;
        if (!eol && ch >= CH_ZERO && ch <= CH_NINE) begin
            grown = acc * 35'd10 + (ch - CH_ZERO);
            acc = (grown > VALUE_MAX) ? VALUE_MAX : grown[VALUE_W-1:0];
            in_num = 1'b1;
            return 1'b0;
        end
        if (!eol && ch == CH_SPACE) begin
            if (!in_num)
                return 1'b0;
            if (close_value(got, v)) begin
                res = halt_with(ST_LONG);
                return 1'b1;
            end
            res.has_value = 1'b1;
            res.value = v;
            res.sequence_id = cur_part;
            res.status = ST_OK;
            return 1'b1;
        end
        if (!eol && ch == CH_SEMI) begin
            if (cur_part) begin
                res = halt_with(ST_FORMAT);
                return 1'b1;
            end
            if (close_value(got, v)) begin
                res = halt_with(ST_LONG);
                return 1'b1;
            end
            res.has_value = got;
            res.value = v;
            res.sequence_id = 1'b0;
            res.last_in_sequence = 1'b1;
            res.seq_length = value_count;
            res.status = ST_OK;
            cur_part = 1'b1;
            value_count = '0;
            return 1'b1;
        end
        if (eol) begin
            if (close_value(got, v)) begin
                res = halt_with(ST_LONG);
                return 1'b1;
            end
            if (!cur_part) begin
                // empty first part closes the data set
                if (value_count == 0) begin
                    res.status = ST_END;
                    halted = 1'b1;
                    return 1'b1;
                end
                res = halt_with(ST_FORMAT);
                return 1'b1;
            end
            res.has_value = got;
            res.value = v;
            res.sequence_id = 1'b1;
            res.last_in_sequence = 1'b1;
            res.seq_length = value_count;
            res.status = ST_OK;
            cur_part = 1'b0;
            value_count = '0;
            return 1'b1;
        end
        res = halt_with(ST_FORMAT);
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
    endtask

    task automatic compare_result(input out_item_t want, input out_item_t seen);
        if (seen.has_value !== want.has_value)
            note_mismatch("has_value", want.has_value, seen.has_value);
        if (seen.value !== want.value)
            note_mismatch("value", want.value, seen.value);
        if (seen.sequence_id !== want.sequence_id)
            note_mismatch("sequence_id", want.sequence_id, seen.sequence_id);
        if (seen.last_in_sequence !== want.last_in_sequence)
            note_mismatch("last_in_sequence", want.last_in_sequence, seen.last_in_sequence);
        if (seen.seq_length !== want.seq_length)
            note_mismatch("seq_length", want.seq_length, seen.seq_length);
        if (seen.status !== want.status)
            note_mismatch("status", want.status, seen.status);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_item_t predicted;
        out_item_t head;
        if (!rst_n) begin
            max_len = MAX_LEN_RESET;
            cur_part = 1'b0;
            in_num = 1'b0;
            acc = '0;
            value_count = '0;
            halted = 1'b0;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
            results_due <= 0;
        end
        else begin
            if (cfg_we)
                max_len = cfg_data;
            if (in_valid && !in_stall) begin
                if (tokenize_char(in_data, predicted))
                    expected_results.push_back(predicted);
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected result, expected none, got %p",
                                 $time, out_data);
                end
                else begin
                    head = expected_results.pop_front();
                    compare_result(head, out_data);
                    results_checked++;
                end
            end
            results_due <= expected_results.size();
        end
    end

endmodule

>>> tb/sv/integer_pair_sequence_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_pair_sequence_tokenizer_unit_tb
// Character stream stimulus and verdict for the integer pair tokenizer.
// ----------------------------------------------------------------------------
// A short directed stream covers saturation, empty sequences, repeated
// spaces and end of input in place of a newline. Random well-formed lines
// then run under several length limits and idle patterns, including one long
// output hold-off. The stream is closed by one randomly chosen terminating
// case, after which further items must produce nothing.
// ----------------------------------------------------------------------------
module integer_pair_sequence_tokenizer_unit_tb;
    import itok_pkg::*;

    localparam int ITEMS_PER_PHASE = 270;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {
        END_OF_DATA,
        BAD_CHAR,
        SEMI_TWICE,
        OPEN_LINE,
        TOO_MANY,
        ZERO_LIMIT
    } ending_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;

    int results_due;
    int fail_count;
    int results_checked;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit long_hold    = 1'b0;
    bit hold_done    = 1'b0;
    int lim_eff      = MAX_LEN_RESET;
    int chars_sent   = 0;
    int lines_sent   = 0;
    int settings     = 0;

    int tx_plan[5] = '{0, 87, 0, 14, 14};
    int rx_plan[5] = '{0, 0, 87, 14, 14};

    integer_pair_sequence_tokenizer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    itok_stream_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .results_due     (results_due),
        .fail_count      (fail_count),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("integer_pair_sequence_tokenizer_unit_tb failed");
        $finish;
    end

    // receiver: random stall, plus one long hold-off so the queue backs up
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic send_item(input logic [7:0] ch, input logic eoi);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.char_code <= ch;
        in_data.end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(ch, 1'b0);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_char(s[i]);
    endtask

    task automatic send_gap(input int least);
        int n;
        n = least + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n) send_char(CH_SPACE);
    endtask

    // mostly short numbers, some long enough to saturate
    task automatic send_number();
        int pick;
        int ndig;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            ndig = $urandom_range(1, 3);
        else if (pick < 17)
            ndig = $urandom_range(4, 10);
        else
            ndig = $urandom_range(11, 14);
        repeat (ndig) send_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic send_part(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                send_gap(1);
            send_number();
        end
        send_gap(0);
    endtask

    task automatic send_eol();
        if ($urandom_range(0, 3) == 0)
            send_item(8'($urandom), 1'b1);
        else
            send_char(CH_NEWLINE);
    endtask

    task automatic send_line(input int n0, input int n1);
        send_gap(0);
        send_part(n0);
        send_char(CH_SEMI);
        send_gap(0);
        send_part(n1);
        send_eol();
        lines_sent++;
    endtask

    function automatic int pick_count();
        if (lim_eff <= 16 && $urandom_range(0, 3) == 0)
            return lim_eff;
        return $urandom_range(0, (lim_eff < 5) ? lim_eff : 5);
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] v);
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_eff = (v > MAX_LENGTH) ? MAX_LENGTH : v;
        settings++;
    endtask

    initial
    begin : stimulus
        int         phase_start;
        ending_t    ending;
        logic [7:0] bad;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty parts, end of input over a digit, saturation,
        // doubled spaces, a value pending at the semicolon
        send_text("0;\n");
        send_char(CH_SEMI);
        send_item(8'(CH_ZERO + 5), 1'b1);
        send_text("2147483648  7;");
        send_item('1, 1'b1);
        send_text("; 4 \n");

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            tx_idle_pct = tx_plan[p];
            rx_stall_pct = rx_plan[p];
            case (p)
                0: write_limit(11'd1);
                1: write_limit('1);
                2: write_limit(11'($urandom_range(2, 16)));
                3: write_limit(MAX_LENGTH);
                default: write_limit(11'($urandom_range(1, 8)));
            endcase
            if (p == 0)
                long_hold = 1'b1;
            phase_start = chars_sent;
            while (chars_sent - phase_start < ITEMS_PER_PHASE)
                send_line(pick_count(), pick_count());
        end

        // close the stream with one terminating case
        wait_idle();
        ending = ending_t'($urandom_range(0, 5));
        case (ending)
            END_OF_DATA:
            begin
                send_gap(0);
                send_eol();
            end
            BAD_CHAR:
            begin
                if ($urandom_range(0, 1))
                    send_char(CH_SEMI);
                if ($urandom_range(0, 1))
                    send_number();
                do
                    bad = 8'($urandom);
                while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_SPACE ||
                       bad == CH_SEMI || bad == CH_NEWLINE);
                send_char(bad);
            end
            SEMI_TWICE:
            begin
                send_gap(0);
                send_part(pick_count());
                send_char(CH_SEMI);
                send_part(pick_count());
                send_char(CH_SEMI);
            end
            OPEN_LINE:
            begin
                send_gap(0);
                send_part($urandom_range(1, (lim_eff < 3) ? lim_eff : 3));
                send_eol();
            end
            TOO_MANY:
            begin
                if ($urandom_range(0, 1))
                    send_char(CH_SEMI);
                repeat (lim_eff + 1)
                begin
                    send_number();
                    send_gap(1);
                end
            end
            default:
            begin
                // a zero limit rejects the very first value
                write_limit('0);
                send_gap(0);
                send_number();
                case ($urandom_range(0, 2))
                    0: send_char(CH_SPACE);
                    1: send_char(CH_SEMI);
                    default: send_char(CH_NEWLINE);
                endcase
            end
        endcase

        // block is halted now; all of this must be dropped silently
        repeat (16) send_item(8'($urandom), 1'($urandom));
        wait_idle();

        $display("Covered %0d characters in %0d lines under %0d limit settings,",
                 chars_sent, lines_sent, settings);
        $display("%0d results checked, stream closed by the %s case, %0d mismatches.",
                 results_checked, ending.name(), fail_count);
        if (fail_count == 0 && results_due == 0)
            $display("integer_pair_sequence_tokenizer_unit_tb passed");
        else
            $display("integer_pair_sequence_tokenizer_unit_tb failed");
        $finish;
    end

endmodule
